@@ hdl/mp2d_pkg.sv @@
// Shared constants for the 2D max pooling stream: register codes, field widths,
// bounds and parameter defaults. No dependencies.
`default_nettype none
package mp2d_pkg;

	// default module parameters
	localparam int DEF_MAX_WIDTH    = 256;
	localparam int DEF_MAX_CHANNELS = 16;
	localparam int DEF_MAX_WINDOW   = 8;
	localparam int DEF_SAMPLE_BITS  = 16;

	// configuration channel
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH  = 3'd4;

	// register field widths as written
	localparam int IMAGE_WIDTH_W   = 9;
	localparam int IMAGE_HEIGHT_W  = 13;
	localparam int CHANNEL_COUNT_W = 5;
	localparam int WINDOW_W        = 4;

	// frame height bound and the counter width that holds it
	localparam int HEIGHT_MAX = 4096;
	localparam int HT_W       = 13;

endpackage
`default_nettype wire

@@ hdl/mp2d_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module mp2d_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ hdl/max_pool_2d_stream.sv @@
// Non-overlapping 2D max pooling over a raster stream (channels innermost).
// Pipeline: the store is read at the accepting edge, the running maximum is updated in stage s1
// and written back as the word leaves s1, and a pooled word loads into the output register as
// it leaves s1, at the edge that also writes the store back, and raises m_axis_tvalid.
// Throughput: one sample per cycle, set by the single read/modify/write pass over the store;
// the input stalls only while a pooled word waits in s1 behind an untaken output word.
// Reset: arst_n clears position counters, pipeline and output valid; registers return to their
// reset values. The running-max store is not cleared: each window's first sample writes first.
`default_nettype none
module max_pool_2d_stream
	import mp2d_pkg::*;
#(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
	parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
	parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
	localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration write channel
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// sample stream in
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [TDATA_W-1:0]    s_axis_tdata,   // [SAMPLE_BITS-1:0] sample, rest zero
	// pooled stream out
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic      [TDATA_W-1:0]    m_axis_tdata,   // [SAMPLE_BITS-1:0] pooled_value, rest zero
	output logic                       m_axis_tlast    // last_of_frame
);

	localparam int DEPTH  = MAX_WIDTH * MAX_CHANNELS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COL_W  = $clog2(MAX_WIDTH + 1);
	localparam int CH_W   = $clog2(MAX_CHANNELS + 1);
	localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
	localparam int CS_W   = COL_W + WIN_W;   // column sums
	localparam int RS_W   = HT_W + WIN_W;    // row sums

	// configuration registers, held clamped to their bounds
	logic [COL_W-1:0] width_q;
	logic [HT_W-1:0]  height_q;
	logic [CH_W-1:0]  chans_q;
	logic [WIN_W-1:0] win_h_q;
	logic [WIN_W-1:0] win_w_q;

	// raster position
	logic [COL_W-1:0] col_q;
	logic [COL_W-1:0] pcol_q;
	logic [HT_W-1:0]  row_q;
	logic [CH_W-1:0]  ch_q;
	logic [WIN_W-1:0] cph_q;
	logic [WIN_W-1:0] rph_q;

	// update stage
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [ADDR_W-1:0]      addr_s1;
	logic                   first_s1;
	logic                   inwin_s1;
	logic                   emit_s1;
	logic                   last_s1;

	// last write, forwarded over the read-during-write of the next word
	logic                   fwd_v_q;
	logic [ADDR_W-1:0]      fwd_addr_q;
	logic [SAMPLE_BITS-1:0] fwd_data_q;

	// output register
	logic                   out_v_q;
	logic [SAMPLE_BITS-1:0] out_data_q;
	logic                   out_last_q;

	logic                   accept;
	logic                   cfg_wr;
	logic                   go_s1;
	logic                   wr_en;
	logic [SAMPLE_BITS-1:0] rd_data;
	logic [SAMPLE_BITS-1:0] prev_max;
	logic [SAMPLE_BITS-1:0] cur_max;
	logic [ADDR_W-1:0]      rd_addr;

	logic ch_last, col_last, row_last, cph_last, rph_last;
	logic in_rows, in_cols, rows_end, cols_end;

	logic [IMAGE_WIDTH_W-1:0]   cfg_w_f;
	logic [IMAGE_HEIGHT_W-1:0]  cfg_h_f;
	logic [CHANNEL_COUNT_W-1:0] cfg_c_f;
	logic [WINDOW_W-1:0]        cfg_win_f;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	// the update stage moves on unless it holds a pooled word and the output is blocked
	assign go_s1         = !valid_s1 || !emit_s1 || !out_v_q || m_axis_tready;
	assign s_axis_tready = go_s1;
	assign accept        = s_axis_tvalid & s_axis_tready;

	// position decode
	assign ch_last  = (ch_q == chans_q - CH_W'(1));
	assign col_last = (col_q == width_q - COL_W'(1));
	assign row_last = (row_q == height_q - HT_W'(1));
	assign cph_last = (cph_q == win_w_q - WIN_W'(1));
	assign rph_last = (rph_q == win_h_q - WIN_W'(1));

	// a window block counts only if it fits inside the frame
	assign in_rows = (RS_W'(row_q) - RS_W'(rph_q) + RS_W'(win_h_q)) <= RS_W'(height_q);
	assign in_cols = (CS_W'(col_q) - CS_W'(cph_q) + CS_W'(win_w_q)) <= CS_W'(width_q);
	// no further whole block below / to the right
	assign rows_end = (RS_W'(row_q) + RS_W'(1) + RS_W'(win_h_q)) > RS_W'(height_q);
	assign cols_end = (CS_W'(col_q) + CS_W'(1) + CS_W'(win_w_q)) > CS_W'(width_q);

	assign rd_addr = ADDR_W'(pcol_q) * ADDR_W'(MAX_CHANNELS) + ADDR_W'(ch_q);

	// configuration field slices
	assign cfg_w_f   = cfg_data[IMAGE_WIDTH_W-1:0];
	assign cfg_h_f   = cfg_data[IMAGE_HEIGHT_W-1:0];
	assign cfg_c_f   = cfg_data[CHANNEL_COUNT_W-1:0];
	assign cfg_win_f = cfg_data[WINDOW_W-1:0];

	// configuration: zero reads as one, anything above the bound saturates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= COL_W'(1);
			height_q <= HT_W'(1);
			chans_q  <= CH_W'(1);
			win_h_q  <= WIN_W'(2 > MAX_WINDOW ? MAX_WINDOW : 2);
			win_w_q  <= WIN_W'(2 > MAX_WINDOW ? MAX_WINDOW : 2);
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH: begin
					if (cfg_w_f == '0) width_q <= COL_W'(1);
					else if (32'(cfg_w_f) > MAX_WIDTH) width_q <= COL_W'(MAX_WIDTH);
					else width_q <= COL_W'(cfg_w_f);
				end
				CFG_IMAGE_HEIGHT: begin
					if (cfg_h_f == '0) height_q <= HT_W'(1);
					else if (32'(cfg_h_f) > HEIGHT_MAX) height_q <= HT_W'(HEIGHT_MAX);
					else height_q <= HT_W'(cfg_h_f);
				end
				CFG_CHANNEL_COUNT: begin
					if (cfg_c_f == '0) chans_q <= CH_W'(1);
					else if (32'(cfg_c_f) > MAX_CHANNELS) chans_q <= CH_W'(MAX_CHANNELS);
					else chans_q <= CH_W'(cfg_c_f);
				end
				CFG_WINDOW_HEIGHT: begin
					if (cfg_win_f == '0) win_h_q <= WIN_W'(1);
					else if (32'(cfg_win_f) > MAX_WINDOW) win_h_q <= WIN_W'(MAX_WINDOW);
					else win_h_q <= WIN_W'(cfg_win_f);
				end
				CFG_WINDOW_WIDTH: begin
					if (cfg_win_f == '0) win_w_q <= WIN_W'(1);
					else if (32'(cfg_win_f) > MAX_WINDOW) win_w_q <= WIN_W'(MAX_WINDOW);
					else win_w_q <= WIN_W'(cfg_win_f);
				end
				default: begin
				end
			endcase
		end
	end

	// raster position: advance per accepted word, restart on a known register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			pcol_q <= '0;
			row_q  <= '0;
			ch_q   <= '0;
			cph_q  <= '0;
			rph_q  <= '0;
		end else if (cfg_wr && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT ||
				cfg_index == CFG_CHANNEL_COUNT || cfg_index == CFG_WINDOW_HEIGHT ||
				cfg_index == CFG_WINDOW_WIDTH)) begin
			col_q  <= '0;
			pcol_q <= '0;
			row_q  <= '0;
			ch_q   <= '0;
			cph_q  <= '0;
			rph_q  <= '0;
		end else if (accept) begin
			if (!ch_last) begin
				ch_q <= ch_q + CH_W'(1);
			end else begin
				ch_q <= '0;
				if (col_last) begin
					col_q  <= '0;
					pcol_q <= '0;
					cph_q  <= '0;
					if (row_last) begin
						row_q <= '0;
						rph_q <= '0;
					end else begin
						row_q <= row_q + HT_W'(1);
						rph_q <= rph_last ? '0 : rph_q + WIN_W'(1);
					end
				end else begin
					col_q <= col_q + COL_W'(1);
					cph_q <= cph_last ? '0 : cph_q + WIN_W'(1);
					if (cph_last) pcol_q <= pcol_q + COL_W'(1);
				end
			end
		end
	end

	// update stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (go_s1) begin
			valid_s1 <= accept;
		end
	end

	// update stage payload: load with each accepted word
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= s_axis_tdata[SAMPLE_BITS-1:0];
			addr_s1   <= rd_addr;
			first_s1  <= (rph_q == '0) && (cph_q == '0);
			inwin_s1  <= in_rows && in_cols;
			emit_s1   <= in_rows && in_cols && rph_last && cph_last;
			last_s1   <= rows_end && cols_end && ch_last;
		end
	end

	mp2d_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(addr_s1),
		.wr_data(cur_max),
		.rd_en  (accept),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// the store returns old data when the previous word wrote the same entry: forward it
	assign prev_max = (fwd_v_q && fwd_addr_q == addr_s1) ? fwd_data_q : rd_data;

	always_comb begin
		if (first_s1) begin
			cur_max = sample_s1;
		end else if ($signed(sample_s1) > $signed(prev_max)) begin
			cur_max = sample_s1;
		end else begin
			cur_max = prev_max;
		end
	end

	// write back once, as the word leaves the stage
	assign wr_en = valid_s1 && inwin_s1 && go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
		end else if (wr_en) begin
			fwd_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= cur_max;
		end
	end

	// output register: load a pooled word, hold it until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (valid_s1 && emit_s1 && go_s1) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && emit_s1 && go_s1) begin
			out_data_q <= cur_max;
			out_last_q <= last_s1;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = TDATA_W'(out_data_q);
	assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

@@ verif/tb_max_pool_2d_stream.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for max_pool_2d_stream: random sample streams, random stalls on
// both stream sides and register settings from 1x1 up to saturated bounds.
// Depends on mp2d_pkg and the max_pool_2d_stream RTL (with its mp2d_ram store) only.
module tb_max_pool_2d_stream;
	import mp2d_pkg::*;

	localparam int SW       = DEF_SAMPLE_BITS;
	localparam int TW       = ((SW + 7) / 8) * 8;
	localparam int SLOTS    = DEF_MAX_WIDTH * DEF_MAX_CHANNELS;
	// indexes 5..7 address no register; a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 3'd5;
	localparam int TARGET_SAMPLES = 1950;
	localparam int MAX_REPORTS    = 50;

	typedef struct packed {
		logic signed [SW-1:0] value;
		logic                 last;
	} pooled_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_valid = 1'b0;
	logic                  s_axis_tready;
	logic [TW-1:0]         s_data = '0;     // [SW-1:0] sample
	logic                  m_axis_tvalid;
	logic                  m_ready = 1'b0;
	logic [TW-1:0]         m_axis_tdata;    // [SW-1:0] pooled_value
	logic                  m_axis_tlast;    // last_of_frame

	max_pool_2d_stream i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Pooling predictor: its own copy of the registers, raster position and
	// running maxima, stepped once per accepted sample word.
	// ------------------------------------------------------------------
	int img_w = 1, img_h = 1, chans = 1, win_h = 2, win_w = 2;
	int pos_row, pos_col, pos_chan, phase_row, phase_col;
	logic signed [SW-1:0] running_max [SLOTS];
	pooled_t pooled_expect [$];

	function automatic int bound_reg(input int v, input int hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_IMAGE_WIDTH:   img_w = bound_reg(int'(val[IMAGE_WIDTH_W-1:0]), DEF_MAX_WIDTH);
			CFG_IMAGE_HEIGHT:  img_h = bound_reg(int'(val[IMAGE_HEIGHT_W-1:0]), HEIGHT_MAX);
			CFG_CHANNEL_COUNT: chans = bound_reg(int'(val[CHANNEL_COUNT_W-1:0]),
				DEF_MAX_CHANNELS);
			CFG_WINDOW_HEIGHT: win_h = bound_reg(int'(val[WINDOW_W-1:0]), DEF_MAX_WINDOW);
			CFG_WINDOW_WIDTH:  win_w = bound_reg(int'(val[WINDOW_W-1:0]), DEF_MAX_WINDOW);
			default: return;    // no register here: position is kept
		endcase
		// any real register write restarts the frame; maxima stay
		pos_row = 0;
		pos_col = 0;
		pos_chan = 0;
		phase_row = 0;
		phase_col = 0;
	endfunction

	function automatic void fold_sample(input logic signed [SW-1:0] s);
		int full_rows, full_cols, slot;
		logic signed [SW-1:0] best;
		pooled_t word;
		full_rows = img_h - img_h % win_h;
		full_cols = img_w - img_w % win_w;
		// only samples inside a whole window take part
		if (pos_row < full_rows && pos_col < full_cols) begin
			slot = ((pos_col / win_w) * DEF_MAX_CHANNELS + pos_chan) % SLOTS;
			if (phase_row == 0 && phase_col == 0) begin
				best = s;
			end else begin
				best = running_max[slot];
				if (s > best) best = s;
			end
			running_max[slot] = best;
			// bottom-right sample of the window: emit its maximum
			if (phase_row == win_h - 1 && phase_col == win_w - 1) begin
				word.value = best;
				word.last = (pos_row == full_rows - 1) && (pos_col == full_cols - 1)
					&& (pos_chan == chans - 1);
				pooled_expect = {pooled_expect, word};
			end
		end
		// advance the raster position, channels innermost
		pos_chan++;
		if (pos_chan >= chans) begin
			pos_chan = 0;
			pos_col++;
			phase_col++;
			if (phase_col >= win_w) phase_col = 0;
			if (pos_col >= img_w) begin
				pos_col = 0;
				phase_col = 0;
				pos_row++;
				phase_row++;
				if (phase_row >= win_h) phase_row = 0;
				if (pos_row >= img_h) begin
					pos_row = 0;
					phase_row = 0;
				end
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// Driver: sample words from the pending queue, a random gap after each
	// word, and a random stall after each pooled word on the master side.
	// Everything changes on the falling edge.
	// ------------------------------------------------------------------
	logic [SW-1:0] pending [$];
	bit in_taken, out_taken;    // handshakes seen at the last rising edge
	bit quiet;                  // no gaps and no stalls in this phase
	int in_gap, out_stall;

	always @(negedge clk) begin : drive
		logic          nxt_valid;
		logic [TW-1:0] nxt_data;
		if (!arst_n) begin
			s_valid <= 1'b0;
			m_ready <= 1'b0;
		end else begin
			nxt_valid = s_valid;
			nxt_data = s_data;
			// hold the word until it is taken, then idle or load the next one
			if (!s_valid || in_taken) begin
				nxt_valid = 1'b0;
				if (in_gap > 0) begin
					in_gap--;
				end else if (pending.size() > 0) begin
					nxt_valid = 1'b1;
					nxt_data = TW'(pending.pop_front());
					in_gap = quiet ? 0 : $urandom_range(0, 7);
				end
			end
			s_valid <= nxt_valid;
			s_data <= nxt_data;

			if (out_taken) out_stall = quiet ? 0 : $urandom_range(0, 7);
			if (out_stall > 0) begin
				m_ready <= 1'b0;
				out_stall--;
			end else begin
				m_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: fold accepted samples into the predictor first, then check
	// every pooled word against the oldest expectation.
	// ------------------------------------------------------------------
	int errors, samples_in, words_seen;

	always @(posedge clk) begin : watch
		pooled_t want;
		in_taken = arst_n && s_valid && s_axis_tready;
		out_taken = arst_n && m_axis_tvalid && m_ready;
		if (in_taken) begin
			fold_sample(s_data[SW-1:0]);
			samples_in++;
		end
		if (out_taken) begin
			words_seen++;
			if (pooled_expect.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected pooled word, expected none, got value %0d last %0b",
						$time, $signed(m_axis_tdata[SW-1:0]), m_axis_tlast);
			end else begin
				want = pooled_expect.pop_front();
				if (m_axis_tdata[SW-1:0] !== want.value) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: pooled value expected %0d, got %0d", $time,
							want.value, $signed(m_axis_tdata[SW-1:0]));
				end
				if (m_axis_tlast !== want.last) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: last of frame expected %0b, got %0b", $time,
							want.last, m_axis_tlast);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	int samples_sent, reg_writes, settings_run;

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, val);
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_setting(input logic [CFG_DATA_W-1:0] w, h, c, wh, ww);
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, h);
		write_reg(CFG_CHANNEL_COUNT, c);
		write_reg(CFG_WINDOW_HEIGHT, wh);
		write_reg(CFG_WINDOW_WIDTH, ww);
		settings_run++;
	endtask

	task automatic push_word(input logic [SW-1:0] v);
		pending = {pending, v};
		samples_sent++;
	endtask

	// wait until every sample is taken and every pooled word has come
	task automatic drain();
		while (pending.size() > 0 || s_valid || pooled_expect.size() > 0) @(posedge clk);
	endtask

	// drain, then let trailing samples that emit nothing clear the pipeline
	task automatic settle();
		drain();
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [SW-1:0] random_sample();
		case ($urandom_range(0, 7))
			0: return {1'b1, {(SW-1){1'b0}}};
			1: return {1'b0, {(SW-1){1'b1}}};
			2: return SW'($signed($urandom_range(0, 7)) - 4);   // small values make ties
			default: return SW'($urandom);
		endcase
	endfunction

	task automatic choose_setting();
		logic [CFG_DATA_W-1:0] w, h, c, wh, ww;
		case ($urandom_range(0, 11))
			0: begin    // widest row, single channel
				w = $urandom_range(0, 1) ? 13'h1FF : 13'($urandom_range(200, 256));
				h = 13'($urandom_range(1, 2));
				c = 1;
				wh = 1;
				ww = 13'($urandom_range(1, 8));
			end
			1: begin    // all channels
				w = 13'($urandom_range(1, 4));
				h = 13'($urandom_range(1, 4));
				c = $urandom_range(0, 1) ? 13'h1F : 13'd16;
				wh = 13'($urandom_range(1, 2));
				ww = 13'($urandom_range(1, 2));
			end
			2: begin    // large windows
				w = 13'($urandom_range(8, 16));
				h = 13'($urandom_range(8, 16));
				c = 1;
				wh = $urandom_range(0, 1) ? 13'hF : 13'($urandom_range(5, 8));
				ww = $urandom_range(0, 1) ? 13'hF : 13'($urandom_range(5, 8));
			end
			3: begin    // raw words: unused high bits, out-of-range values
				w = 13'($urandom);
				h = 13'($urandom);
				c = 13'($urandom);
				wh = 13'($urandom);
				ww = 13'($urandom);
			end
			4: begin    // tallest frame
				w = 13'($urandom_range(1, 2));
				h = $urandom_range(0, 1) ? 13'h1FFF : 13'd4096;
				c = 1;
				wh = 8;
				ww = 1;
			end
			5: begin    // zeros read as one
				w = 13'($urandom_range(0, 3));
				h = 13'($urandom_range(0, 3));
				c = 0;
				wh = 13'($urandom_range(0, 2));
				ww = 0;
			end
			default: begin
				w = 13'($urandom_range(1, 10));
				h = 13'($urandom_range(1, 8));
				c = 13'($urandom_range(1, 4));
				wh = 13'($urandom_range(1, 4));
				ww = 13'($urandom_range(1, 4));
			end
		endcase
		write_setting(w, h, c, wh, ww);
		// now and then poke an address with no register behind it
		if ($urandom_range(0, 4) == 0)
			write_reg(CFG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(0, 2)),
				CFG_DATA_W'($urandom));
	endtask

	initial begin : stimulus
		logic [SW-1:0] corner [12];
		int frame, count;
		bit pause;
		corner = '{16'h8000, 16'h7FFF, 16'h8001, 16'hFFFF, 16'h1234, 16'h1234,
			16'hFFFF, 16'h8000, 16'h8000, 16'h0000, 16'h7FFF, 16'h7FFF};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: 2x2 window on a 1x1 frame never fills
		push_word(16'h7FFF);
		push_word(16'h8000);
		settle();

		// all registers written zero: 1x1 frame, 1x1 window, each word last
		write_setting(0, 0, 0, 0, 0);
		push_word(16'h8000);
		push_word(16'h7FFF);
		push_word(16'h0000);
		push_word(16'hFFFF);
		settle();

		// 3x2 frame, two channels, 2x2 window: the last column is dropped
		write_setting(3, 2, 2, 2, 2);
		foreach (corner[i]) push_word(corner[i]);
		settle();

		// every register above its bound saturates
		write_setting(13'h1FF, 13'h1FFF, 13'h1F, 13'hF, 13'hF);
		repeat (6) push_word(random_sample());
		settle();

		// random settings, mostly whole frames, some cut short
		while (samples_sent < TARGET_SAMPLES) begin
			quiet = ($urandom_range(0, 3) == 0);
			choose_setting();
			frame = img_w * img_h * chans;
			if (frame > 600) count = $urandom_range(40, 150);
			else if ($urandom_range(0, 5) == 0) count = $urandom_range(1, frame);
			else count = frame * $urandom_range(1, 3);
			if (count > 800) count = frame;
			// keep the total close to the target
			if (count > TARGET_SAMPLES - samples_sent) count = TARGET_SAMPLES - samples_sent;
			// hold the sender mid-phase until the block has caught up
			pause = (settings_run == 5) || ($urandom_range(0, 2) == 0);
			for (int i = 0; i < count; i++) begin
				if (pause && i == count / 2) drain();
				push_word(random_sample());
			end
			settle();
		end

		quiet = 1'b0;
		drain();
		repeat (20) @(posedge clk);
		$display("covered %0d samples and %0d pooled words under %0d register settings",
			samples_in, words_seen, settings_run);
		$display("(%0d register writes, idle gaps and stalls of 0 to 7 cycles)", reg_writes);
		if (errors == 0) begin
			$display("tb_max_pool_2d_stream passed");
		end else begin
			$display("tb_max_pool_2d_stream failed");
		end
		$finish;
	end

	// watchdog well beyond the slowest legal run
	initial begin : watchdog
		#5_000_000;
		$display("tb_max_pool_2d_stream failed");
		$finish;
	end

endmodule
